>>> rtl/core/assc_pkg.sv
// shared types and constants of the substitute signal stack slot manager
package assc_pkg;

	// pool geometry
	localparam int SLOT_COUNT = 8;
	localparam int SLOT_BYTES = 16384;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam longint SPAN   = longint'(SLOT_COUNT) * longint'(SLOT_BYTES);
	localparam int SPAN_W     = $clog2(SPAN);

	// field widths
	localparam int ADDR_W = 48;
	localparam int SIZE_W = 32;
	localparam int LIM_W  = 15;
	localparam int IDX_W  = 2;

	// config register reset values
	localparam logic [LIM_W-1:0] USABLE_MIN_RST = LIM_W'(16384);
	localparam logic [LIM_W-1:0] KERNEL_MIN_RST = LIM_W'(2048);

	typedef enum logic [1:0] {
		CMD_CHECK    = 2'd0,
		CMD_COMMIT   = 2'd1,
		CMD_EXIT     = 2'd2,
		CMD_FREE_ALL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PERM    = 2'd1,
		ST_INVALID = 2'd2,
		ST_NOMEM   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_ENABLE  = 2'd0,
		MODE_ONSTACK = 2'd1,
		MODE_DISABLE = 2'd2,
		MODE_BAD     = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_SLAB_BASE  = 2'd0,
		CFG_USABLE_MIN = 2'd1,
		CFG_KERNEL_MIN = 2'd2,
		CFG_NONE       = 2'd3
	} cfg_idx_t;

	// command broadcast to every slot cell
	typedef struct packed {
		logic              clear_all;
		logic              drop;
		logic              reuse;
		logic              alloc;
		logic              in_slab;
		logic [SPAN_W-1:0] off;
		logic [ADDR_W-1:0] wr_base;
		logic [SIZE_W-1:0] wr_size;
	} cell_ctrl_t;

	// what one slot cell reports back
	typedef struct packed {
		logic              hit;
		logic              claim;
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} cell_stat_t;

endpackage

>>> rtl/core/assc_cell.sv
// one slot of the pool: busy flag, guest record, range match and priority claim
module assc_cell
	import assc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] idx,
	input  cell_ctrl_t        ctrl,
	input  logic              taken_in,
	output logic              taken_out,
	output cell_stat_t        stat
);

	logic              busy_q;
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [SPAN_W:0]   lo;
	logic [SPAN_W:0]   hi;
	logic [SPAN_W:0]   off_x;
	logic              hit;
	logic              claim;
	logic              wr;

	// address window of this slot inside the slab
	assign lo    = (SPAN_W+1)'(idx) * (SPAN_W+1)'(SLOT_BYTES);
	assign hi    = lo + (SPAN_W+1)'(SLOT_BYTES);
	assign off_x = {1'b0, ctrl.off};
	assign hit   = ctrl.in_slab && (off_x >= lo) && (off_x < hi);

	// lowest free slot wins, token passes to the next cell
	assign claim     = ctrl.alloc && !taken_in && !busy_q;
	assign taken_out = taken_in || !busy_q;
	assign wr        = claim || (ctrl.reuse && hit);

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctrl.clear_all) begin
			busy_q <= 1'b0;
		end else if (claim) begin
			busy_q <= 1'b1;
		end else if (ctrl.drop && hit) begin
			busy_q <= 1'b0;
		end
	end

	// guest record
	always_ff @(posedge clk) begin
		if (wr) begin
			base_q <= ctrl.wr_base;
			size_q <= ctrl.wr_size;
		end
	end

	assign stat.hit   = hit;
	assign stat.claim = claim;
	assign stat.base  = base_q;
	assign stat.size  = size_q;

endmodule

>>> rtl/core/alt_stack_slot_substitution.sv
// top level of the substitute signal stack slot manager
//
// Input channel: in_valid / in_stall with cmd, the current stack, the guest
// pointer and the requested stack. Output channel: out_valid / out_stall with
// status, the old stack and the installed stack. Every input beat gives
// exactly one output beat. Config port: cfg_valid / cfg_ready (always ready),
// cfg_index selects slab_base, usable_min or kernel_min; other indexes are
// dropped. Write config only while no beat is in flight.
// An accepted beat is captured into the request registers, then passes the
// S_EXEC state through the chain of slot cells, where range match, priority
// claim and record write happen, and is registered into the result
// registers; the next beat is taken in the cycle the result leaves, so a new
// beat is not taken before the previous result is out.
// While out_stall is high the result holds and in_stall stays high.
// Reset frees all slots and loads the config defaults; guest records are
// left as they are.
module alt_stack_slot_substitution
	import assc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// config write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	// request
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [ADDR_W-1:0] cur_sp,
	input  logic [SIZE_W-1:0] cur_size,
	input  logic              cur_autodisarm,
	input  logic [ADDR_W-1:0] guest_ptr,
	input  logic              new_present,
	input  logic [ADDR_W-1:0] new_sp,
	input  logic [SIZE_W-1:0] new_size,
	input  logic [1:0]        new_mode,
	input  logic              new_autodisarm,
	input  logic              want_old,
	// result
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] old_sp,
	output logic [SIZE_W-1:0] old_size,
	output logic [1:0]        old_mode,
	output logic              old_autodisarm,
	output logic [ADDR_W-1:0] out_sp,
	output logic [SIZE_W-1:0] out_size,
	output logic [1:0]        out_mode,
	output logic              out_autodisarm
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	// config registers
	logic [ADDR_W-1:0] slab_base_q;
	logic [LIM_W-1:0]  usable_min_q;
	logic [LIM_W-1:0]  kernel_min_q;

	// captured request
	logic [1:0]        cmd_q;
	logic [ADDR_W-1:0] cur_sp_q;
	logic [SIZE_W-1:0] cur_size_q;
	logic              cur_ad_q;
	logic [ADDR_W-1:0] guest_ptr_q;
	logic              present_q;
	logic [ADDR_W-1:0] new_sp_q;
	logic [SIZE_W-1:0] new_size_q;
	logic [1:0]        new_mode_q;
	logic              new_ad_q;
	logic              want_old_q;

	// result registers
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] old_sp_q;
	logic [SIZE_W-1:0] old_size_q;
	logic [1:0]        old_mode_q;
	logic              old_ad_q;
	logic [ADDR_W-1:0] out_sp_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [1:0]        out_mode_q;
	logic              out_ad_q;

	logic in_accept;
	logic exec;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = !((state_q == S_IDLE) || ((state_q == S_DONE) && !out_stall));
	assign in_accept = in_valid && !in_stall;
	assign out_valid = (state_q == S_DONE);
	assign exec      = (state_q == S_EXEC);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_DONE;
				S_DONE: begin
					if (!out_stall) state_q <= in_valid ? S_EXEC : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slab_base_q  <= '0;
			usable_min_q <= USABLE_MIN_RST;
			kernel_min_q <= KERNEL_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLAB_BASE:  slab_base_q  <= cfg_data;
				CFG_USABLE_MIN: usable_min_q <= cfg_data[LIM_W-1:0];
				CFG_KERNEL_MIN: kernel_min_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q       <= cmd;
			cur_sp_q    <= cur_sp;
			cur_size_q  <= cur_size;
			cur_ad_q    <= cur_autodisarm;
			guest_ptr_q <= guest_ptr;
			present_q   <= new_present;
			new_sp_q    <= new_sp;
			new_size_q  <= new_size;
			new_mode_q  <= new_mode;
			new_ad_q    <= new_autodisarm;
			want_old_q  <= want_old;
		end
	end

	// slab window of the current stack
	logic [ADDR_W:0]   diff;
	logic              in_slab;
	assign diff    = {1'b0, cur_sp_q} - {1'b0, slab_base_q};
	assign in_slab = (cur_size_q != '0) && !diff[ADDR_W]
		&& (diff[ADDR_W-1:0] < ADDR_W'(SPAN));

	// guest pointer inside the current stack
	logic [ADDR_W-1:0] gdist;
	logic              guest_inside;
	assign gdist        = guest_ptr_q - cur_sp_q;
	assign guest_inside = !cur_ad_q && (guest_ptr_q > cur_sp_q)
		&& (gdist <= ADDR_W'(cur_size_q));

	// commit decisions
	logic is_commit;
	logic is_disable;
	logic undersized;
	logic do_reuse;
	logic do_alloc;
	logic do_release;
	assign is_commit  = (cmd_q == CMD_COMMIT);
	assign is_disable = (new_mode_q == MODE_DISABLE);
	assign undersized = (new_size_q < SIZE_W'(usable_min_q));
	assign do_reuse   = is_commit && !is_disable && undersized && in_slab;
	assign do_alloc   = is_commit && !is_disable && undersized && !in_slab;
	assign do_release = (is_commit && !(!is_disable && undersized))
		|| (cmd_q == CMD_EXIT);

	cell_ctrl_t ctrl;
	always_comb begin
		ctrl.clear_all = exec && (cmd_q == CMD_FREE_ALL);
		ctrl.drop      = exec && do_release;
		ctrl.reuse     = exec && do_reuse;
		ctrl.alloc     = exec && do_alloc;
		ctrl.in_slab   = in_slab;
		ctrl.off       = diff[SPAN_W-1:0];
		ctrl.wr_base   = new_sp_q;
		ctrl.wr_size   = new_size_q;
	end

	// chain of slot cells
	cell_stat_t      stat [SLOT_COUNT];
	logic [SLOT_COUNT:0] taken;
	assign taken[0] = 1'b0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		assc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (SLOT_W'(i)),
			.ctrl      (ctrl),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.stat      (stat[i])
		);
	end

	// gather cell reports: record of the current slot and index of the new one
	logic [ADDR_W-1:0] rec_base;
	logic [SIZE_W-1:0] rec_size;
	logic [SLOT_W-1:0] k_new;
	logic              got_slot;
	always_comb begin
		rec_base = '0;
		rec_size = '0;
		k_new    = '0;
		got_slot = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (stat[i].hit) begin
				rec_base = rec_base | stat[i].base;
				rec_size = rec_size | stat[i].size;
			end
			if ((do_reuse && stat[i].hit) || stat[i].claim) begin
				k_new    = k_new | SLOT_W'(i);
				got_slot = 1'b1;
			end
		end
	end

	logic [ADDR_W-1:0] slot_addr;
	assign slot_addr = slab_base_q + ADDR_W'(k_new) * ADDR_W'(SLOT_BYTES);

	// result of this beat
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= ST_OK;
			old_sp_q   <= '0;
			old_size_q <= '0;
			old_mode_q <= '0;
			old_ad_q   <= 1'b0;
			out_sp_q   <= '0;
			out_size_q <= '0;
			out_mode_q <= '0;
			out_ad_q   <= 1'b0;
			priority case (1'b1)
				cmd_q == CMD_CHECK: begin
					priority if (present_q && guest_inside) begin
						status_q <= ST_PERM;
					end else if (present_q && new_mode_q == MODE_BAD) begin
						status_q <= ST_INVALID;
					end else if (present_q && !is_disable
						&& new_size_q < SIZE_W'(kernel_min_q)) begin
						status_q <= ST_NOMEM;
					end else if (want_old_q) begin
						old_sp_q   <= in_slab ? rec_base : cur_sp_q;
						old_size_q <= in_slab ? rec_size : cur_size_q;
						old_mode_q <= (cur_size_q == '0) ? MODE_DISABLE
							: (guest_inside ? MODE_ONSTACK : MODE_ENABLE);
						old_ad_q   <= cur_ad_q;
					end
				end
				is_commit: begin
					if (is_disable) begin
						out_sp_q   <= '0;
						out_size_q <= '0;
					end else if (undersized && got_slot) begin
						out_sp_q   <= slot_addr;
						out_size_q <= SIZE_W'(SLOT_BYTES);
					end else begin
						out_sp_q   <= new_sp_q;
						out_size_q <= new_size_q;
					end
					out_mode_q <= new_mode_q;
					out_ad_q   <= new_ad_q;
				end
				default: ;
			endcase
		end
	end

	assign status         = status_q;
	assign old_sp         = old_sp_q;
	assign old_size       = old_size_q;
	assign old_mode       = old_mode_q;
	assign old_autodisarm = old_ad_q;
	assign out_sp         = out_sp_q;
	assign out_size       = out_size_q;
	assign out_mode       = out_mode_q;
	assign out_autodisarm = out_ad_q;

endmodule
